// File: hw/rtl/ile_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ile_pkg: shared types and constants of the ising lattice energy engine
// operation codes, register indexes, sequencer states, memory control word
// ============================================================================
package ile_pkg;

    localparam int SIDE_DEFAULT = 64;
    localparam int COORD_IN_W   = 6;
    localparam int OP_W         = 3;
    localparam int VALUE_W      = 22;
    localparam int CFG_W        = 8;
    localparam int CFG_IDX_W    = 1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 3'd0,
        OP_FLIP   = 3'd1,
        OP_DELTA  = 3'd2,
        OP_FILL   = 3'd3,
        OP_MAGNET = 3'd4,
        OP_ENERGY = 3'd5
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUPLING = 1'b0,
        CFG_FIELD    = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_FLIP_RD,
        ST_FLIP_WR,
        ST_DE_RD,
        ST_DE_WAIT,
        ST_DE_CALC,
        ST_FILL,
        ST_WALK,
        ST_WALK_DRAIN,
        ST_WALK_MUL,
        ST_OUT
    } state_t;

    // control word from the sequencer to the lattice memory
    typedef struct packed {
        logic rd_en;
        logic spin_we;
        logic act_we;
        logic spin_wd;
        logic act_wd;
    } mem_ctl_t;

endpackage

// File: hw/rtl/ile_lattice_mem.sv
`timescale 1ns / 1ps
// ============================================================================
// ile_lattice_mem: spin and active-mark storage of the lattice
// two one-bit arrays, one write port, two registered read ports
// ============================================================================
module ile_lattice_mem
    import ile_pkg::*;
#(
    parameter int SIDE = SIDE_DEFAULT
)
(
    input  logic                           clk,
    input  mem_ctl_t                       ctl,
    input  logic [$clog2(SIDE*SIDE)-1:0]   wr_addr,
    input  logic [$clog2(SIDE*SIDE)-1:0]   rd_addr_a,
    input  logic [$clog2(SIDE*SIDE)-1:0]   rd_addr_b,
    output logic                           spin_a,
    output logic                           act_a,
    output logic                           spin_b,
    output logic                           act_b
);

    localparam int SITES = SIDE * SIDE;

    logic spin_mem [SITES];
    logic act_mem  [SITES];

    logic spin_a_reg;
    logic act_a_reg;
    logic spin_b_reg;
    logic act_b_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.spin_we)
        begin
            spin_mem[wr_addr] <= ctl.spin_wd;
        end
        if (ctl.act_we)
        begin
            act_mem[wr_addr] <= ctl.act_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            spin_a_reg <= spin_mem[rd_addr_a];
            act_a_reg  <= act_mem[rd_addr_a];
            spin_b_reg <= spin_mem[rd_addr_b];
            act_b_reg  <= act_mem[rd_addr_b];
        end
    end

    assign spin_a = spin_a_reg;
    assign act_a  = act_a_reg;
    assign spin_b = spin_b_reg;
    assign act_b  = act_b_reg;

endmodule

// File: hw/rtl/ising_lattice_energy_engine.sv
`timescale 1ns / 1ps
// ============================================================================
// ising_lattice_energy_engine: 2d ising lattice with energy queries
// keeps a SIDE x SIDE periodic lattice of spins and active marks in memory
// and runs one operation per input word
// ============================================================================
// usage: a word is taken when start is high and busy is low; busy stays high
// while it runs and its result comes back as a one-cycle done pulse with
// value, which the receiver must take in that cycle (there is no hold-off).
// delta energy makes five lattice reads over two memory read ports, then
// the multiply-add; fill makes one memory write per site; magnetization and
// total energy walk one site per cycle through the dual-port memory, down
// neighbor on the second port, then total energy takes one multiply. after
// reset the block clears the lattice to all +1 and active, one site per
// cycle, with busy high; register writes are taken at any time but belong
// in idle periods. col and row are reduced modulo SIDE. value saturates to
// 22 bits signed, which only matters for SIDE above 64.
// ============================================================================
module ising_lattice_energy_engine
    import ile_pkg::*;
#(
    parameter int SIDE = SIDE_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // word in
    input  logic                        start,
    output logic                        busy,
    input  logic [OP_W-1:0]             operation,
    input  logic [COORD_IN_W-1:0]       col,
    input  logic [COORD_IN_W-1:0]       row,
    input  logic                        spin_bit,
    input  logic                        active_bit,
    // result out
    output logic                        done,
    output logic signed [VALUE_W-1:0]   value,
    // register writes
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data
);

    localparam int SITES = SIDE * SIDE;
    localparam int CW    = $clog2(SIDE);
    localparam int AW    = $clog2(SITES);
    // bond sum spans -2*SITES .. 2*SITES
    localparam int BW    = $clog2(2 * SITES + 1) + 1;
    localparam int PW    = BW + CFG_W;
    localparam int RW    = (PW > VALUE_W) ? PW : VALUE_W;
    localparam int INS   = 1 << COORD_IN_W;

    localparam logic signed [RW-1:0] V_MAX = RW'((1 <<< (VALUE_W - 1)) - 1);
    localparam logic signed [RW-1:0] V_MIN = ~V_MAX;

    localparam logic [CW-1:0] C_LAST = CW'(SIDE - 1);

    // ------------------------------------------------------------------
    // coordinate reduction table, col and row modulo SIDE
    // ------------------------------------------------------------------
    logic [CW-1:0] mod_tab [INS];

    for (genvar g = 0; g < INS; g++)
    begin : g_mod
        assign mod_tab[g] = CW'(g % SIDE);
    end

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] xc,
                                              input logic [CW-1:0] yc);
        addr_of = AW'(AW'(yc) * AW'(SIDE)) + AW'(xc);
    endfunction

    // spin of an active site as +1 / -1, defects give 0
    function automatic logic signed [3:0] mspin(input logic s, input logic a);
        mspin = a ? (s ? 4'sd1 : -4'sd1) : 4'sd0;
    endfunction

    // bond product of two spins
    function automatic logic signed [2:0] bond(input logic s, input logic t);
        bond = (s == t) ? 3'sd1 : -3'sd1;
    endfunction

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t                     state_reg,     state_next;
    logic                       done_reg,      done_next;
    logic                       wk_v_reg,      wk_v_next;
    logic                       de_v_reg,      de_v_next;
    logic signed [CFG_W-1:0]    coupling_reg,  coupling_next;
    logic signed [CFG_W-1:0]    field_reg,     field_next;
    logic [CW-1:0]              wx_reg,        wx_next;
    logic [CW-1:0]              wy_reg,        wy_next;

    op_t                        op_reg,        op_next;
    logic [CW-1:0]              x_reg,         x_next;
    logic [CW-1:0]              y_reg,         y_next;
    logic                       sb_reg,        sb_next;
    logic                       ab_reg,        ab_next;
    logic [1:0]                 step_reg,      step_next;
    logic [1:0]                 de_step_reg,   de_step_next;
    logic                       c_spin_reg,    c_spin_next;
    logic                       c_act_reg,     c_act_next;
    logic signed [3:0]          n_reg,         n_next;
    logic                       wk_first_reg,  wk_first_next;
    logic                       wk_last_reg,   wk_last_next;
    logic                       prev_reg,      prev_next;
    logic                       first_reg,     first_next;
    logic signed [BW-1:0]       mag_reg,       mag_next;
    logic signed [BW-1:0]       bond_reg,      bond_next;
    logic signed [RW-1:0]       res_reg,       res_next;
    logic signed [VALUE_W-1:0]  value_reg,     value_next;

    // ------------------------------------------------------------------
    // lattice memory
    // ------------------------------------------------------------------
    mem_ctl_t       mem_ctl;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr_a;
    logic [AW-1:0]  rd_addr_b;
    logic           spin_a;
    logic           act_a;
    logic           spin_b;
    logic           act_b;

    ile_lattice_mem #(
        .SIDE      (SIDE)
    ) u_mem (
        .clk       (clk),
        .ctl       (mem_ctl),
        .wr_addr   (wr_addr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .spin_a    (spin_a),
        .act_a     (act_a),
        .spin_b    (spin_b),
        .act_b     (act_b)
    );

    // ------------------------------------------------------------------
    // neighbors with periodic wrap
    // ------------------------------------------------------------------
    logic [CW-1:0] x_plus, x_minus, y_plus, y_minus, wy_plus;
    logic          wx_end, sweep_end;

    assign x_plus    = (x_reg == C_LAST) ? '0 : x_reg + 1'b1;
    assign x_minus   = (x_reg == '0) ? C_LAST : x_reg - 1'b1;
    assign y_plus    = (y_reg == C_LAST) ? '0 : y_reg + 1'b1;
    assign y_minus   = (y_reg == '0) ? C_LAST : y_reg - 1'b1;
    assign wy_plus   = (wy_reg == C_LAST) ? '0 : wy_reg + 1'b1;
    assign wx_end    = (wx_reg == C_LAST);
    assign sweep_end = wx_end && (wy_reg == C_LAST);

    // ------------------------------------------------------------------
    // arithmetic of the final cycles
    // ------------------------------------------------------------------
    logic signed [11:0]    jn;
    logic signed [12:0]    jnh;
    logic signed [RW-1:0]  de_twice;
    logic signed [RW-1:0]  de_res;
    logic signed [RW-1:0]  j_w;
    logic signed [RW-1:0]  nb_w;
    logic signed [RW-1:0]  e_res;

    // delta energy 2*s*(J*n + H), zero at a defect site
    assign jn       = coupling_reg * n_reg;
    assign jnh      = 13'(jn) + 13'(field_reg);
    assign de_twice = RW'(jnh) <<< 1;
    assign de_res   = !c_act_reg ? '0 : (c_spin_reg ? de_twice : -de_twice);

    // total energy -J * bond sum
    assign j_w   = RW'(coupling_reg);
    assign nb_w  = -RW'(bond_reg);
    assign e_res = j_w * nb_w;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        wk_v_next     = 1'b0;
        de_v_next     = 1'b0;
        coupling_next = coupling_reg;
        field_next    = field_reg;
        wx_next       = wx_reg;
        wy_next       = wy_reg;
        op_next       = op_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        sb_next       = sb_reg;
        ab_next       = ab_reg;
        step_next     = step_reg;
        de_step_next  = de_step_reg;
        c_spin_next   = c_spin_reg;
        c_act_next    = c_act_reg;
        n_next        = n_reg;
        wk_first_next = wk_first_reg;
        wk_last_next  = wk_last_reg;
        prev_next     = prev_reg;
        first_next    = first_reg;
        mag_next      = mag_reg;
        bond_next     = bond_reg;
        res_next      = res_reg;
        value_next    = value_reg;
        mem_ctl       = '0;
        wr_addr       = addr_of(x_reg, y_reg);
        rd_addr_a     = addr_of(x_reg, y_reg);
        rd_addr_b     = addr_of(x_reg, y_reg);

        unique case (state_reg)
            ST_CLEAR:
            begin
                // post-reset pass: every site +1 and active
                mem_ctl.spin_we = 1'b1;
                mem_ctl.act_we  = 1'b1;
                mem_ctl.spin_wd = 1'b1;
                mem_ctl.act_wd  = 1'b1;
                wr_addr         = addr_of(wx_reg, wy_reg);
                wx_next         = wx_end ? '0 : wx_reg + 1'b1;
                wy_next         = wx_end ? wy_plus : wy_reg;
                if (sweep_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next   = op_t'(operation);
                    x_next    = mod_tab[col];
                    y_next    = mod_tab[row];
                    sb_next   = spin_bit;
                    ab_next   = active_bit;
                    wx_next   = '0;
                    wy_next   = '0;
                    step_next = '0;
                    mag_next  = '0;
                    bond_next = '0;
                    n_next    = '0;
                    res_next  = '0;
                    unique case (op_t'(operation))
                        OP_LOAD:                state_next = ST_LOAD;
                        OP_FLIP:                state_next = ST_FLIP_RD;
                        OP_DELTA:               state_next = ST_DE_RD;
                        OP_FILL:                state_next = ST_FILL;
                        OP_MAGNET, OP_ENERGY:   state_next = ST_WALK;
                        default:                state_next = ST_OUT;
                    endcase
                end
            end
            ST_LOAD:
            begin
                mem_ctl.spin_we = 1'b1;
                mem_ctl.act_we  = 1'b1;
                mem_ctl.spin_wd = sb_reg;
                mem_ctl.act_wd  = ab_reg;
                state_next      = ST_OUT;
            end
            ST_FLIP_RD:
            begin
                mem_ctl.rd_en = 1'b1;
                state_next    = ST_FLIP_WR;
            end
            ST_FLIP_WR:
            begin
                // active mark is left as it is, defects flip too
                mem_ctl.spin_we = 1'b1;
                mem_ctl.spin_wd = ~spin_a;
                state_next      = ST_OUT;
            end
            ST_DE_RD:
            begin
                // center+right, left+down, up
                mem_ctl.rd_en = 1'b1;
                de_v_next     = 1'b1;
                de_step_next  = step_reg;
                step_next     = step_reg + 1'b1;
                case (step_reg)
                    2'd0:
                    begin
                        rd_addr_a = addr_of(x_reg, y_reg);
                        rd_addr_b = addr_of(x_plus, y_reg);
                    end
                    2'd1:
                    begin
                        rd_addr_a = addr_of(x_minus, y_reg);
                        rd_addr_b = addr_of(x_reg, y_plus);
                    end
                    default:
                    begin
                        rd_addr_a  = addr_of(x_reg, y_minus);
                        rd_addr_b  = addr_of(x_reg, y_minus);
                        state_next = ST_DE_WAIT;
                    end
                endcase
            end
            ST_DE_WAIT:
            begin
                state_next = ST_DE_CALC;
            end
            ST_DE_CALC:
            begin
                res_next   = de_res;
                state_next = ST_OUT;
            end
            ST_FILL:
            begin
                mem_ctl.spin_we = 1'b1;
                mem_ctl.spin_wd = sb_reg;
                wr_addr         = addr_of(wx_reg, wy_reg);
                wx_next         = wx_end ? '0 : wx_reg + 1'b1;
                wy_next         = wx_end ? wy_plus : wy_reg;
                if (sweep_end)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_WALK:
            begin
                // site on port a, its down neighbor on port b
                mem_ctl.rd_en = 1'b1;
                rd_addr_a     = addr_of(wx_reg, wy_reg);
                rd_addr_b     = addr_of(wx_reg, wy_plus);
                wk_v_next     = 1'b1;
                wk_first_next = (wx_reg == '0);
                wk_last_next  = wx_end;
                wx_next       = wx_end ? '0 : wx_reg + 1'b1;
                wy_next       = wx_end ? wy_plus : wy_reg;
                if (sweep_end)
                begin
                    state_next = ST_WALK_DRAIN;
                end
            end
            ST_WALK_DRAIN:
            begin
                state_next = ST_WALK_MUL;
            end
            ST_WALK_MUL:
            begin
                res_next   = (op_reg == OP_ENERGY) ? e_res : RW'(mag_reg);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (res_reg > V_MAX)
                begin
                    value_next = VALUE_W'(V_MAX);
                end
                else if (res_reg < V_MIN)
                begin
                    value_next = VALUE_W'(V_MIN);
                end
                else
                begin
                    value_next = VALUE_W'(res_reg);
                end
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // delta energy read data, which arrives in the cycle after its read
        if (de_v_reg)
        begin
            case (de_step_reg)
                2'd0:
                begin
                    c_spin_next = spin_a;
                    c_act_next  = act_a;
                    n_next      = mspin(spin_b, act_b);
                end
                2'd1:
                begin
                    n_next = n_reg + mspin(spin_a, act_a) + mspin(spin_b, act_b);
                end
                default:
                begin
                    n_next = n_reg + mspin(spin_a, act_a);
                end
            endcase
        end

        // walk accumulation: down bond always, left bond inside a row,
        // wrap bond to the row start at the last column
        if (wk_v_reg)
        begin
            mag_next  = mag_reg + BW'(mspin(spin_a, act_a));
            prev_next = spin_a;
            if (wk_first_reg)
            begin
                first_next = spin_a;
                bond_next  = bond_reg + BW'(bond(spin_a, spin_b));
            end
            else if (wk_last_reg)
            begin
                bond_next = bond_reg + BW'(bond(spin_a, spin_b))
                          + BW'(bond(prev_reg, spin_a)) + BW'(bond(first_reg, spin_a));
            end
            else
            begin
                bond_next = bond_reg + BW'(bond(spin_a, spin_b))
                          + BW'(bond(prev_reg, spin_a));
            end
        end

        // register writes
        if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_COUPLING: coupling_next = cfg_data;
                CFG_FIELD:    field_next    = cfg_data;
                default:      coupling_next = coupling_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            done_reg     <= 1'b0;
            wk_v_reg     <= 1'b0;
            de_v_reg     <= 1'b0;
            coupling_reg <= 8'sd1;
            field_reg    <= 8'sd0;
            wx_reg       <= '0;
            wy_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            wk_v_reg     <= wk_v_next;
            de_v_reg     <= de_v_next;
            coupling_reg <= coupling_next;
            field_reg    <= field_next;
            wx_reg       <= wx_next;
            wy_reg       <= wy_next;
        end
    end

    // word payload and datapath
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        sb_reg       <= sb_next;
        ab_reg       <= ab_next;
        step_reg     <= step_next;
        de_step_reg  <= de_step_next;
        c_spin_reg   <= c_spin_next;
        c_act_reg    <= c_act_next;
        n_reg        <= n_next;
        wk_first_reg <= wk_first_next;
        wk_last_reg  <= wk_last_next;
        prev_reg     <= prev_next;
        first_reg    <= first_next;
        mag_reg      <= mag_next;
        bond_reg     <= bond_next;
        res_reg      <= res_next;
        value_reg    <= value_next;
    end

    assign busy  = (state_reg != ST_IDLE);
    assign done  = done_reg;
    assign value = value_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("word accepted but block not busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result delivered while a word is still running");

    a_write_ops_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (op_reg == OP_LOAD || op_reg == OP_FLIP || op_reg == OP_FILL)
        |-> value == '0)
        else $error("load, flip or fill returned a nonzero value");

    a_walk_only_walking: assert property (@(posedge clk) disable iff (!rst_n)
        wk_v_reg |-> (state_reg == ST_WALK || state_reg == ST_WALK_DRAIN))
        else $error("walk data valid outside a lattice walk");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for the ising lattice energy engine
// keeps a shadow lattice of spins and active marks plus its own copy of the
// coupling and field registers, predicts every result word as each command
// word is taken, and compares it with the done/value pulse that comes back
// ============================================================================
module tb
    import ile_pkg::*;
();

    localparam int SIDE      = SIDE_DEFAULT;
    localparam int SITES     = SIDE * SIDE;
    localparam longint V_MAX = (longint'(1) <<< (VALUE_W - 1)) - 1;
    localparam longint V_MIN = -(longint'(1) <<< (VALUE_W - 1));

    // codes 6 and 7 are not decoded by the block
    localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

    // bound on the run length; even if every one of the roughly 920 words
    // were a whole-lattice op behind the longest gap, a run would end well
    // inside it
    localparam int CYCLE_LIMIT = 20_000_000;

    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [VALUE_W-1:0] value;
    } result_word_t;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [OP_W-1:0]            operation;
    logic [COORD_IN_W-1:0]      col;
    logic [COORD_IN_W-1:0]      row;
    logic                       spin_bit;
    logic                       active_bit;
    logic                       done;
    logic signed [VALUE_W-1:0]  value;
    logic                       cfg_write;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;

    // shadow lattice and registers
    bit                         spin_mem [SITES];
    bit                         act_mem  [SITES];
    logic signed [CFG_W-1:0]    coupling_q;
    logic signed [CFG_W-1:0]    field_q;

    result_word_t               pending_results [$];
    int                         fail_count;
    int                         cycle_count;
    bit                         no_gaps;
    logic [COORD_IN_W-1:0]      win_col;
    logic [COORD_IN_W-1:0]      win_row;

    ising_lattice_energy_engine dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .col        (col),
        .row        (row),
        .spin_bit   (spin_bit),
        .active_bit (active_bit),
        .done       (done),
        .value      (value),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // lattice predictor
    // ------------------------------------------------------------------

    function automatic int spin_val(int idx);
        return spin_mem[idx] ? 1 : -1;
    endfunction

    // periodic wrap; callers never pass negative coordinates
    function automatic int masked_spin(int x, int y);
        int idx;
        idx = (y % SIDE) * SIDE + (x % SIDE);
        return act_mem[idx] ? spin_val(idx) : 0;
    endfunction

    // updates the shadow state for one command word and returns its result
    function automatic logic signed [VALUE_W-1:0] apply_word(
        logic [OP_W-1:0] op, logic [COORD_IN_W-1:0] c, logic [COORD_IN_W-1:0] r,
        bit sb, bit ab);
        int     x;
        int     y;
        int     idx;
        int     nsum;
        int     jv;
        int     hv;
        longint acc;
        longint bond_sum;
        x        = int'(c) % SIDE;
        y        = int'(r) % SIDE;
        idx      = y * SIDE + x;
        jv       = int'(coupling_q);
        hv       = int'(field_q);
        acc      = 0;
        bond_sum = 0;
        case (op)
            OP_LOAD:
            begin
                spin_mem[idx] = sb;
                act_mem[idx]  = ab;
            end
            // a defect site flips too, its mark stays
            OP_FLIP: spin_mem[idx] = ~spin_mem[idx];
            OP_DELTA:
            begin
                if (act_mem[idx])
                begin
                    nsum = masked_spin(x + 1, y) + masked_spin(x + SIDE - 1, y)
                         + masked_spin(x, y + 1) + masked_spin(x, y + SIDE - 1);
                    acc = longint'(2 * spin_val(idx) * (jv * nsum + hv));
                end
            end
            // marks are kept, only spins change
            OP_FILL:
            begin
                foreach (spin_mem[k]) spin_mem[k] = sb;
            end
            OP_MAGNET:
            begin
                foreach (act_mem[k]) if (act_mem[k]) acc += longint'(spin_val(k));
            end
            // right and down bonds, defects do not matter here
            OP_ENERGY:
            begin
                for (int yy = 0; yy < SIDE; yy++)
                    for (int xx = 0; xx < SIDE; xx++)
                        bond_sum += longint'(spin_val(yy * SIDE + xx)
                                  * (spin_val(yy * SIDE + (xx + 1) % SIDE)
                                   + spin_val(((yy + 1) % SIDE) * SIDE + xx)));
                acc = -longint'(jv) * bond_sum;
            end
            default: ;
        endcase
        if (acc > V_MAX) acc = V_MAX;
        if (acc < V_MIN) acc = V_MIN;
        return acc[VALUE_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------

    // presents one word, optionally after a random gap, and holds start
    // until the block takes it; start stays high afterwards so back-to-back
    // words need no extra assignment
    task automatic send_word(logic [OP_W-1:0] op, logic [COORD_IN_W-1:0] c,
                             logic [COORD_IN_W-1:0] r, bit sb, bit ab);
        int           gap;
        result_word_t predicted;
        @(negedge clk);
        if (!no_gaps && $urandom_range(0, 99) < 15)
        begin
            gap = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (gap)
            begin
                // junk on the fields while start is low
                operation  <= OP_W'($urandom);
                col        <= COORD_IN_W'($urandom);
                row        <= COORD_IN_W'($urandom);
                spin_bit   <= 1'($urandom);
                active_bit <= 1'($urandom);
                @(negedge clk);
            end
        end
        operation  <= op;
        col        <= c;
        row        <= r;
        spin_bit   <= sb;
        active_bit <= ab;
        start      <= 1'b1;
        do @(posedge clk); while (busy);
        predicted.op    = op;
        predicted.value = apply_word(op, c, r, sb, ab);
        pending_results.push_back(predicted);
    endtask

    // drop start and wait until every result is back and the block is idle
    task automatic drain_block();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        while (busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(logic signed [CFG_W-1:0] j, logic signed [CFG_W-1:0] h);
        drain_block();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_COUPLING;
        cfg_data  <= j;
        @(negedge clk);
        cfg_index <= CFG_FIELD;
        cfg_data  <= h;
        @(negedge clk);
        cfg_write <= 1'b0;
        cfg_data  <= CFG_W'($urandom);
        coupling_q = j;
        field_q    = h;
    endtask

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endtask

    // coordinate near the current window (often across the wrap) or anywhere
    function automatic logic [COORD_IN_W-1:0] pick_coord(logic [COORD_IN_W-1:0] center);
        if ($urandom_range(0, 99) < 60)
            return center + COORD_IN_W'($urandom_range(0, 4)) - COORD_IN_W'(2);
        return COORD_IN_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // result checker: done is a single-cycle strobe, sampled at the edge
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        result_word_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                note_failure($sformatf("result word %0d with nothing pending", value));
            end
            else
            begin
                want = pending_results.pop_front();
                if (value !== want.value)
                    note_failure($sformatf("op %0d: value expected %0d, got %0d",
                                           want.op, want.value, value));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // totals of the freshly cleared lattice under reset registers
    task automatic test_reset_lattice();
        send_word(OP_MAGNET, '0, '0, 1'b0, 1'b0);
        send_word(OP_ENERGY, '1, '1, 1'b1, 1'b1);
    endtask

    // corner sites, wraparound neighbors, defect flip and defect query
    task automatic test_edge_sites();
        send_word(OP_LOAD,  6'd0,  6'd0,  1'b0, 1'b1);
        send_word(OP_LOAD,  6'd63, 6'd63, 1'b1, 1'b0);
        send_word(OP_LOAD,  6'd63, 6'd0,  1'b0, 1'b1);
        send_word(OP_LOAD,  6'd0,  6'd63, 1'b1, 1'b0);
        send_word(OP_FLIP,  6'd63, 6'd63, 1'b0, 1'b0);
        send_word(OP_DELTA, 6'd0,  6'd0,  1'b0, 1'b0);
        send_word(OP_DELTA, 6'd63, 6'd63, 1'b1, 1'b1);
        send_word(OP_DELTA, 6'd63, 6'd0,  1'b0, 1'b1);
        send_word(OP_DELTA, 6'd0,  6'd62, 1'b1, 1'b0);
    endtask

    // codes 6 and 7 leave the lattice alone and return zero
    task automatic test_unused_codes();
        send_word(OP_UNUSED_A, 6'd21, 6'd42, 1'b1, 1'b0);
        send_word(OP_UNUSED_B, 6'd42, 6'd21, 1'b0, 1'b1);
        send_word(OP_DELTA,    6'd0,  6'd0,  1'b0, 1'b0);
    endtask

    // fill keeps the defect marks set up above
    task automatic test_fill_and_totals();
        send_word(OP_FILL,   6'd5, 6'd5, 1'b0, 1'b1);
        send_word(OP_MAGNET, 6'd0, 6'd0, 1'b0, 1'b0);
        send_word(OP_ENERGY, 6'd0, 6'd0, 1'b0, 1'b0);
        send_word(OP_FILL,   6'd9, 6'd9, 1'b1, 1'b0);
        send_word(OP_DELTA,  6'd1, 6'd0, 1'b0, 1'b0);
        send_word(OP_MAGNET, 6'd0, 6'd0, 1'b1, 1'b1);
    endtask

    // random mix: mostly loads and delta queries around a small window,
    // so neighborhoods fill with varied spins and defects
    task automatic run_random_words(int count);
        int                    pick;
        logic [OP_W-1:0]       op;
        logic [COORD_IN_W-1:0] c;
        logic [COORD_IN_W-1:0] r;
        bit                    ab;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 999);
            if      (pick < 350) op = OP_LOAD;
            else if (pick < 500) op = OP_FLIP;
            else if (pick < 900) op = OP_DELTA;
            else if (pick < 915) op = OP_FILL;
            else if (pick < 945) op = OP_MAGNET;
            else if (pick < 975) op = OP_ENERGY;
            else if (pick < 987) op = OP_UNUSED_A;
            else                 op = OP_UNUSED_B;
            c  = pick_coord(win_col);
            r  = pick_coord(win_row);
            ab = ($urandom_range(0, 99) < 75);
            send_word(op, c, r, 1'($urandom), ab);
            if ($urandom_range(0, 99) < 3)
            begin
                win_col = $urandom_range(0, 99) < 50 ? '0 : COORD_IN_W'($urandom);
                win_row = $urandom_range(0, 99) < 50 ? '1 : COORD_IN_W'($urandom);
            end
        end
    endtask

    // strongest coupling against the most negative field, first stretch
    // with no gaps at all
    task automatic test_extreme_positive_coupling();
        set_config(8'sd127, -8'sd128);
        win_col = '0;
        win_row = '0;
        no_gaps = 1'b1;
        run_random_words(100);
        no_gaps = 1'b0;
        run_random_words(150);
    endtask

    task automatic test_extreme_negative_coupling();
        set_config(-8'sd128, 8'sd127);
        win_col = '1;
        win_row = 6'd31;
        run_random_words(250);
    endtask

    // no coupling, no field: every delta is zero
    task automatic test_zero_coupling();
        set_config(8'sd0, 8'sd0);
        run_random_words(100);
    endtask

    task automatic test_random_registers();
        for (int p = 0; p < 3; p++)
        begin
            set_config(CFG_W'($urandom), CFG_W'($urandom));
            win_col = COORD_IN_W'($urandom);
            win_row = COORD_IN_W'($urandom);
            run_random_words(100);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        operation  = '0;
        col        = '0;
        row        = '0;
        spin_bit   = 1'b0;
        active_bit = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_COUPLING;
        cfg_data   = '0;
        fail_count = 0;
        no_gaps    = 1'b0;
        win_col    = '0;
        win_row    = '0;
        // reset state of the shadow copy: all +1, all active, J=1, H=0
        foreach (spin_mem[k]) spin_mem[k] = 1'b1;
        foreach (act_mem[k])  act_mem[k]  = 1'b1;
        coupling_q = 8'sd1;
        field_q    = 8'sd0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // the clearing pass after reset shows as busy; send_word waits on it
        test_reset_lattice();
        test_edge_sites();
        test_unused_codes();
        test_fill_and_totals();
        test_extreme_positive_coupling();
        test_extreme_negative_coupling();
        test_zero_coupling();
        test_random_registers();

        drain_block();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
